// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL files, included by fall_detector.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== hdl/fd_pkg.sv =====
`default_nettype none
package fd_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_GRAVITY_SQ_LOW   = 3'd0,
      CSR_GRAVITY_SQ_HIGH  = 3'd1,
      CSR_FALLEN_ANGLE     = 3'd2,
      CSR_ROLL_LIMIT       = 3'd3,
      CSR_FORWARD_LIMIT    = 3'd4,
      CSR_BACKWARD_LIMIT   = 3'd5,
      CSR_FALLEN_TIME      = 3'd6
   } csr_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // Reset values: 0.8 g and 1.2 g squared (1 g = 981 cm/s^2), angles in Q4.12
   localparam logic [31:0] RST_GRAVITY_SQ_LOW  = 32'd615911;
   localparam logic [31:0] RST_GRAVITY_SQ_HIGH = 32'd1385800;
   localparam logic [14:0] RST_FALLEN_ANGLE    = 15'd4506;  // 1.1 rad
   localparam logic [14:0] RST_ROLL_LIMIT      = 15'd2253;  // 0.55 rad
   localparam logic [14:0] RST_FORWARD_LIMIT   = 15'd2253;  // 0.55 rad
   localparam logic [14:0] RST_BACKWARD_LIMIT  = 15'd1843;  // 0.45 rad
   localparam logic [15:0] RST_FALLEN_TIME     = 16'd100;   // ms

   typedef struct packed {
      logic [31:0] gravity_sq_low;
      logic [31:0] gravity_sq_high;
      logic [14:0] fallen_angle;
      logic [14:0] roll_falling_limit;
      logic [14:0] forward_falling_limit;
      logic [14:0] backward_falling_limit;
      logic [15:0] fallen_time_limit;
   } cfg_type;

   typedef struct packed {
      logic               sample_valid;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic [15:0]        elapsed_ms;
   } sample_type;

   // Per-sample decisions handed to the timer stage
   typedef struct packed {
      logic        sample_valid;
      logic        near_g;
      logic        tilted;
      logic        x_dominant;
      logic        x_positive;
      logic        y_positive;
      logic        falling_left;
      logic        falling_right;
      logic        falling_forward;
      logic        falling_backward;
      logic [15:0] elapsed_ms;
   } feat_type;

endpackage
`default_nettype wire

// ===== hdl/fd_req_if.sv =====
`default_nettype none
interface fd_req_if;
   logic               valid;
   logic               ready;
   logic               sample_valid;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic [15:0]        elapsed_ms;

   modport source (
      output valid, sample_valid, accel_x, accel_y, accel_z,
             roll_angle, pitch_angle, elapsed_ms,
      input  ready
   );
   modport sink (
      input  valid, sample_valid, accel_x, accel_y, accel_z,
             roll_angle, pitch_angle, elapsed_ms,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/fd_rsp_if.sv =====
`default_nettype none
interface fd_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_valid;
   logic       fallen;
   logic       fallen_left;
   logic       fallen_right;
   logic       fallen_front;
   logic       fallen_back;
   logic       falling_left;
   logic       falling_right;
   logic       falling_forward;
   logic       falling_backward;
   logic [2:0] falling_count;

   modport source (
      output valid, result_valid, fallen, fallen_left, fallen_right,
             fallen_front, fallen_back, falling_left, falling_right,
             falling_forward, falling_backward, falling_count,
      input  ready
   );
   modport sink (
      input  valid, result_valid, fallen, fallen_left, fallen_right,
             fallen_front, fallen_back, falling_left, falling_right,
             falling_forward, falling_backward, falling_count,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/fd_csr_if.sv =====
`default_nettype none
interface fd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fd_pkg::CSR_INDEX_W-1:0] index;
   logic [fd_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/fall_detector.sv =====
`default_nettype none
// Fall detector.
// One sensor sample per transfer on req_ch (sample_valid, accelerations in
// cm/s^2, roll/pitch in Q4.12 rad, elapsed_ms); one result per sample on
// rsp_ch. Configuration registers are written on csr_ch (always ready); the
// user must write them only while no sample is in flight; the block does not check.
// Throughput: one sample per cycle while rsp_ch is not stalled. Pipeline:
// three registers (stage 1, stage 2, output); a sample transferred on req_ch
// passes through them in order to rsp_ch. The lying timer is updated in the
// last stage, so each sample sees the timer left by the one before it.
// Back pressure: while a result waits with rsp_ch.ready low, the whole
// pipeline holds and req_ch.ready is low; bubbles drain as soon as the
// output register is free.
// Reset: pipeline empty, lying timer zero, registers at their defaults.
// Invalid samples give result_valid 0 with all flags clear and leave the
// timer as it was.
module fall_detector #(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   fd_req_if.sink    req_ch,
   fd_rsp_if.source  rsp_ch,
   fd_csr_if.sink    csr_ch
);
   import fd_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned SUM_W = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

   typedef struct packed {
      logic       result_valid;
      logic       fallen;
      logic       fallen_left;
      logic       fallen_right;
      logic       fallen_front;
      logic       fallen_back;
      logic       falling_left;
      logic       falling_right;
      logic       falling_forward;
      logic       falling_backward;
      logic [2:0] falling_count;
   } result_type;

   cfg_type                cfg_ff, cfg_in;
   sample_type             smp;
   logic                   adv;
   logic                   feat_valid;
   feat_type               feat;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [SUM_W-1:0]       timer_sum;
   logic [TIMER_WIDTH-1:0] timer_sat, timer_next;
   logic                   is_fallen, not_fallen;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   // Configuration writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_GRAVITY_SQ_LOW:  cfg_in.gravity_sq_low         = csr_ch.wdata;
            CSR_GRAVITY_SQ_HIGH: cfg_in.gravity_sq_high        = csr_ch.wdata;
            CSR_FALLEN_ANGLE:    cfg_in.fallen_angle           = csr_ch.wdata[14:0];
            CSR_ROLL_LIMIT:      cfg_in.roll_falling_limit     = csr_ch.wdata[14:0];
            CSR_FORWARD_LIMIT:   cfg_in.forward_falling_limit  = csr_ch.wdata[14:0];
            CSR_BACKWARD_LIMIT:  cfg_in.backward_falling_limit = csr_ch.wdata[14:0];
            CSR_FALLEN_TIME:     cfg_in.fallen_time_limit      = csr_ch.wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_sq_low         <= RST_GRAVITY_SQ_LOW;
         cfg_ff.gravity_sq_high        <= RST_GRAVITY_SQ_HIGH;
         cfg_ff.fallen_angle           <= RST_FALLEN_ANGLE;
         cfg_ff.roll_falling_limit     <= RST_ROLL_LIMIT;
         cfg_ff.forward_falling_limit  <= RST_FORWARD_LIMIT;
         cfg_ff.backward_falling_limit <= RST_BACKWARD_LIMIT;
         cfg_ff.fallen_time_limit      <= RST_FALLEN_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline advances whenever the output register is free or draining
   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_comb begin
      smp.sample_valid = req_ch.sample_valid;
      smp.accel_x      = req_ch.accel_x;
      smp.accel_y      = req_ch.accel_y;
      smp.accel_z      = req_ch.accel_z;
      smp.roll_angle   = req_ch.roll_angle;
      smp.pitch_angle  = req_ch.pitch_angle;
      smp.elapsed_ms   = req_ch.elapsed_ms;
   end

   fd_feature u_feature (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_ch.valid),
      .smp        (smp),
      .cfg        (cfg_ff),
      .feat_valid (feat_valid),
      .feat       (feat)
   );

   // Lying timer: saturating add while lying near 1 g, hold on invalid samples, else clear
   always_comb begin
      timer_sum = SUM_W'(timer_ff) + SUM_W'(feat.elapsed_ms);
      timer_sat = (|timer_sum[SUM_W-1:TIMER_WIDTH]) ? {TIMER_WIDTH{1'b1}}
                                                    : timer_sum[TIMER_WIDTH-1:0];
      if (!feat.sample_valid) begin
         timer_next = timer_ff;
      end else if (feat.near_g && feat.tilted) begin
         timer_next = timer_sat;
      end else begin
         timer_next = '0;
      end
      timer_in = (adv && feat_valid) ? timer_next : timer_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
      end else begin
         timer_ff <= timer_in;
      end
   end

   // Result decode
   always_comb begin
      is_fallen  = feat.sample_valid
                   && (SUM_W'(timer_next) > SUM_W'(cfg_ff.fallen_time_limit));
      not_fallen = feat.sample_valid && !is_fallen;
      rsp_in.result_valid     = feat.sample_valid;
      rsp_in.fallen           = is_fallen;
      rsp_in.fallen_front     = is_fallen && feat.x_dominant && feat.x_positive;
      rsp_in.fallen_back      = is_fallen && feat.x_dominant && !feat.x_positive;
      rsp_in.fallen_left      = is_fallen && !feat.x_dominant && feat.y_positive;
      rsp_in.fallen_right     = is_fallen && !feat.x_dominant && !feat.y_positive;
      rsp_in.falling_left     = not_fallen && feat.falling_left;
      rsp_in.falling_right    = not_fallen && feat.falling_right;
      rsp_in.falling_forward  = not_fallen && feat.falling_forward;
      rsp_in.falling_backward = not_fallen && feat.falling_backward;
      rsp_in.falling_count    = {2'b00, rsp_in.falling_left}
                              + {2'b00, rsp_in.falling_right}
                              + {2'b00, rsp_in.falling_forward}
                              + {2'b00, rsp_in.falling_backward};
      rsp_valid_in = adv ? feat_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // Output channel
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.result_valid     = rsp_ff.result_valid;
   assign rsp_ch.fallen           = rsp_ff.fallen;
   assign rsp_ch.fallen_left      = rsp_ff.fallen_left;
   assign rsp_ch.fallen_right     = rsp_ff.fallen_right;
   assign rsp_ch.fallen_front     = rsp_ff.fallen_front;
   assign rsp_ch.fallen_back      = rsp_ff.fallen_back;
   assign rsp_ch.falling_left     = rsp_ff.falling_left;
   assign rsp_ch.falling_right    = rsp_ff.falling_right;
   assign rsp_ch.falling_forward  = rsp_ff.falling_forward;
   assign rsp_ch.falling_backward = rsp_ff.falling_backward;
   assign rsp_ch.falling_count    = rsp_ff.falling_count;

   // Checks
   `ASSERT_IMPL(a_fallen_one_dir, clock, reset, rsp_valid_ff && rsp_ff.fallen, $onehot({rsp_ff.fallen_left, rsp_ff.fallen_right, rsp_ff.fallen_front, rsp_ff.fallen_back}))
   `ASSERT_IMPL(a_fallen_no_falling, clock, reset, rsp_valid_ff && rsp_ff.fallen, rsp_ff.falling_count == 3'd0)
   `ASSERT_IMPL(a_invalid_quiet, clock, reset, rsp_valid_ff && !rsp_ff.result_valid, !rsp_ff.fallen && (rsp_ff.falling_count == 3'd0))
   `ASSERT_NEXT(a_timer_hold_stall, clock, reset, !adv, $stable(timer_ff))

endmodule
`default_nettype wire

// ===== hdl/fd_feature.sv =====
`default_nettype none
// Two-stage front end: squares and angle compares, then magnitude window.
module fd_feature (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire fd_pkg::sample_type smp,
   input  wire fd_pkg::cfg_type    cfg,
   output logic                    feat_valid,
   output fd_pkg::feat_type        feat
);
   import fd_pkg::*;

   typedef struct packed {
      logic        sample_valid;
      logic [30:0] sq_x;
      logic [30:0] sq_y;
      logic [30:0] sq_z;
      logic        tilted;
      logic        x_dominant;
      logic        x_positive;
      logic        y_positive;
      logic        falling_left;
      logic        falling_right;
      logic        falling_forward;
      logic        falling_backward;
      logic [15:0] elapsed_ms;
   } s1_type;

   logic               s1_valid_ff, s1_valid_in;
   s1_type             s1_ff, s1_in;
   logic               s2_valid_ff, s2_valid_in;
   feat_type           s2_ff, s2_in;

   logic signed [31:0] prod_x, prod_y, prod_z;
   logic signed [16:0] roll17, pitch17, ax17, ay17;
   logic [16:0]        roll_mag, pitch_mag, ax_mag, ay_mag;
   logic [16:0]        angle_lim;
   logic signed [16:0] roll_lim, fwd_lim, neg_roll_lim, neg_back_lim;
   logic [31:0]        sq_sum;

   // Stage 1: squares, magnitudes and threshold compares
   always_comb begin
      prod_x  = smp.accel_x * smp.accel_x;
      prod_y  = smp.accel_y * smp.accel_y;
      prod_z  = smp.accel_z * smp.accel_z;
      roll17  = {smp.roll_angle[15], smp.roll_angle};
      pitch17 = {smp.pitch_angle[15], smp.pitch_angle};
      ax17    = {smp.accel_x[15], smp.accel_x};
      ay17    = {smp.accel_y[15], smp.accel_y};
      roll_mag  = roll17[16]  ? 17'(-roll17)  : 17'(roll17);
      pitch_mag = pitch17[16] ? 17'(-pitch17) : 17'(pitch17);
      ax_mag    = ax17[16]    ? 17'(-ax17)    : 17'(ax17);
      ay_mag    = ay17[16]    ? 17'(-ay17)    : 17'(ay17);
      angle_lim    = {2'b00, cfg.fallen_angle};
      roll_lim     = $signed({2'b00, cfg.roll_falling_limit});
      fwd_lim      = $signed({2'b00, cfg.forward_falling_limit});
      neg_roll_lim = -roll_lim;
      neg_back_lim = -$signed({2'b00, cfg.backward_falling_limit});

      s1_in.sample_valid     = smp.sample_valid;
      s1_in.sq_x             = prod_x[30:0];
      s1_in.sq_y             = prod_y[30:0];
      s1_in.sq_z             = prod_z[30:0];
      s1_in.tilted           = (roll_mag > angle_lim) || (pitch_mag > angle_lim);
      s1_in.x_dominant       = ax_mag > ay_mag;
      s1_in.x_positive       = !smp.accel_x[15] && (smp.accel_x != 16'sd0);
      s1_in.y_positive       = !smp.accel_y[15] && (smp.accel_y != 16'sd0);
      s1_in.falling_left     = roll17 < neg_roll_lim;
      s1_in.falling_right    = roll17 > roll_lim;
      s1_in.falling_forward  = pitch17 > fwd_lim;
      s1_in.falling_backward = pitch17 < neg_back_lim;
      s1_in.elapsed_ms       = smp.elapsed_ms;
      s1_valid_in            = adv ? in_valid : s1_valid_ff;
   end

   // Stage 2: squared magnitude against the gravity window
   always_comb begin
      sq_sum = 32'(s1_ff.sq_x) + 32'(s1_ff.sq_y) + 32'(s1_ff.sq_z);
      s2_in.sample_valid     = s1_ff.sample_valid;
      s2_in.near_g           = (sq_sum > cfg.gravity_sq_low)
                               && (sq_sum < cfg.gravity_sq_high);
      s2_in.tilted           = s1_ff.tilted;
      s2_in.x_dominant       = s1_ff.x_dominant;
      s2_in.x_positive       = s1_ff.x_positive;
      s2_in.y_positive       = s1_ff.y_positive;
      s2_in.falling_left     = s1_ff.falling_left;
      s2_in.falling_right    = s1_ff.falling_right;
      s2_in.falling_forward  = s1_ff.falling_forward;
      s2_in.falling_backward = s1_ff.falling_backward;
      s2_in.elapsed_ms       = s1_ff.elapsed_ms;
      s2_valid_in            = adv ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload moves only on advance
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign feat_valid = s2_valid_ff;
   assign feat       = s2_ff;

endmodule
`default_nettype wire

// ===== tb/sv/fall_detector_tb.sv =====
`timescale 1ns / 100ps
module fall_detector_tb;
   import fd_pkg::*;

   localparam int TIMER_W      = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 75;
   localparam int NUM_PHASES   = 6;
   localparam int MAX_REPORTS  = 10;

   // No register lives at this index; writes to it must be dropped
   localparam logic [2:0]  CSR_INDEX_UNUSED = 3'd7;
   localparam logic [31:0] GRAVITY_SQ_MAX   = 32'd3221225472;

   typedef struct packed {
      logic       result_valid;
      logic       fallen;
      logic       fallen_left;
      logic       fallen_right;
      logic       fallen_front;
      logic       fallen_back;
      logic       falling_left;
      logic       falling_right;
      logic       falling_forward;
      logic       falling_backward;
      logic [2:0] falling_count;
   } fall_result_type;

   typedef struct {
      sample_type      smp;
      bit              typed;
      fall_result_type want;
   } stim_row_type;

   localparam fall_result_type RES_INVALID = '0;

   logic clock;
   logic reset;

   fd_req_if req_if ();
   fd_rsp_if rsp_if ();
   fd_csr_if csr_if ();

   fall_detector #(.TIMER_WIDTH(TIMER_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Shadow of the block: register copy and lying timer
   cfg_type              cfg;
   logic [TIMER_W-1:0]   lying_ms;
   fall_result_type      verdict_q[$];
   stim_row_type         dir_rows[$];
   logic [31:0]          reg_words[7];

   int  lie_run     = 0;
   bit  calm        = 1'b0;
   int  stall_left  = 0;
   int  cycle_count = 0;
   int  n_sent      = 0;
   int  n_checked   = 0;
   int  n_bad       = 0;
   int  n_fallen    = 0;
   int  n_falling   = 0;
   int  n_invalid   = 0;
   int  n_settings  = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, verdict_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int iabs(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic fall_result_type falling_only(input bit gl, input bit gr,
                                                    input bit gf, input bit gb);
      fall_result_type r;
      r = '0;
      r.result_valid     = 1'b1;
      r.falling_left     = gl;
      r.falling_right    = gr;
      r.falling_forward  = gf;
      r.falling_backward = gb;
      r.falling_count    = 3'(int'(gl) + int'(gr) + int'(gf) + int'(gb));
      return r;
   endfunction

   function automatic sample_type smp(input bit v, input int ax, input int ay,
                                      input int az, input int roll,
                                      input int pitch, input int ms);
      sample_type s;
      s.sample_valid = v;
      s.accel_x      = 16'(ax);
      s.accel_y      = 16'(ay);
      s.accel_z      = 16'(az);
      s.roll_angle   = 16'(roll);
      s.pitch_angle  = 16'(pitch);
      s.elapsed_ms   = 16'(ms);
      return s;
   endfunction

   // Verdict for one sample; a valid sample advances the lying timer
   function automatic fall_result_type predict_verdict(input sample_type s);
      fall_result_type r;
      int              ax, ay, az, roll, pitch;
      longint          sq, sum, t_max;
      bit              near_g, tilted, is_fallen;
      r = '0;
      if (!s.sample_valid) return r;
      ax    = $signed(s.accel_x);
      ay    = $signed(s.accel_y);
      az    = $signed(s.accel_z);
      roll  = $signed(s.roll_angle);
      pitch = $signed(s.pitch_angle);

      sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
      near_g = (sq > longint'(cfg.gravity_sq_low)) &&
               (sq < longint'(cfg.gravity_sq_high));
      tilted = (iabs(roll) > int'(cfg.fallen_angle)) ||
               (iabs(pitch) > int'(cfg.fallen_angle));

      // saturating timer while lying near 1 g
      t_max = (longint'(1) << TIMER_W) - 1;
      if (near_g && tilted) begin
         sum = longint'(lying_ms) + longint'(s.elapsed_ms);
         lying_ms = (sum > t_max) ? TIMER_W'(t_max) : TIMER_W'(sum);
      end else begin
         lying_ms = '0;
      end

      is_fallen = longint'(lying_ms) > longint'(cfg.fallen_time_limit);
      r.result_valid = 1'b1;
      if (is_fallen) begin
         r.fallen = 1'b1;
         // y axis wins a tie
         if (iabs(ax) > iabs(ay)) begin
            if (ax > 0) r.fallen_front = 1'b1;
            else        r.fallen_back  = 1'b1;
         end else begin
            if (ay > 0) r.fallen_left  = 1'b1;
            else        r.fallen_right = 1'b1;
         end
      end else begin
         r.falling_left     = roll < -int'(cfg.roll_falling_limit);
         r.falling_right    = roll > int'(cfg.roll_falling_limit);
         r.falling_forward  = pitch > int'(cfg.forward_falling_limit);
         r.falling_backward = pitch < -int'(cfg.backward_falling_limit);
         r.falling_count = 3'(int'(r.falling_left) + int'(r.falling_right) +
                              int'(r.falling_forward) + int'(r.falling_backward));
      end
      return r;
   endfunction

   // Mostly near-1g samples with lying episodes; some pure noise
   function automatic sample_type random_sample();
      sample_type s;
      int         acc[3];
      int         dom, k, tilt, r;
      int         roll, pitch;
      if ($urandom_range(0, 99) < 12) begin
         s.sample_valid = 1'($urandom_range(0, 1));
         s.accel_x      = 16'($urandom);
         s.accel_y      = 16'($urandom);
         s.accel_z      = 16'($urandom);
         s.roll_angle   = 16'($urandom);
         s.pitch_angle  = 16'($urandom);
         s.elapsed_ms   = 16'($urandom);
         return s;
      end
      if (lie_run == 0 && $urandom_range(0, 3) == 0) lie_run = $urandom_range(3, 15);

      s.sample_valid = ($urandom_range(0, 19) != 0);
      dom = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) begin
         acc[k] = $urandom_range(0, 250);
         if ($urandom_range(0, 1)) acc[k] = -acc[k];
      end
      acc[dom] = $urandom_range(850, 1100);
      if ($urandom_range(0, 1)) acc[dom] = -acc[dom];
      if ($urandom_range(0, 9) == 0)
         acc[$urandom_range(0, 2)] = $urandom_range(0, 65535) - 32768;

      roll  = $urandom_range(0, 6000) - 3000;
      pitch = $urandom_range(0, 6000) - 3000;
      if (lie_run > 0) begin
         lie_run--;
         tilt = int'(cfg.fallen_angle) + $urandom_range(0, 3000) - 40;
         if (tilt < 0) tilt = 0;
         if (tilt > 32767) tilt = 32767;
         if ($urandom_range(0, 29) == 0) tilt = 32768;
         if ($urandom_range(0, 1)) tilt = -tilt;
         if ($urandom_range(0, 1)) roll = tilt;
         else                      pitch = tilt;
      end

      r = $urandom_range(0, 99);
      if (r < 80)      s.elapsed_ms = 16'($urandom_range(0, 40));
      else if (r < 95) s.elapsed_ms = 16'($urandom_range(0, 300));
      else             s.elapsed_ms = 16'($urandom);

      s.accel_x     = 16'(acc[0]);
      s.accel_y     = 16'(acc[1]);
      s.accel_z     = 16'(acc[2]);
      s.roll_angle  = 16'(roll);
      s.pitch_angle = 16'(pitch);
      return s;
   endfunction

   function automatic string show_result(input fall_result_type r);
      return $sformatf("v%0b fallen%0b L%0b R%0b F%0b B%0b | fl%0b fr%0b ff%0b fb%0b n%0d",
                       r.result_valid, r.fallen, r.fallen_left, r.fallen_right,
                       r.fallen_front, r.fallen_back, r.falling_left, r.falling_right,
                       r.falling_forward, r.falling_backward, r.falling_count);
   endfunction

   task automatic add_row(input sample_type s, input bit typed,
                          input fall_result_type want);
      stim_row_type row;
      row.smp   = s;
      row.typed = typed;
      row.want  = want;
      dir_rows  = {dir_rows, row};
   endtask

   // One sample transfer, optionally preceded by an idle burst
   task automatic send_sample(input sample_type s, input bit typed,
                              input fall_result_type want);
      int              gap;
      fall_result_type verdict;
      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.sample_valid <= s.sample_valid;
      req_if.accel_x      <= s.accel_x;
      req_if.accel_y      <= s.accel_y;
      req_if.accel_z      <= s.accel_z;
      req_if.roll_angle   <= s.roll_angle;
      req_if.pitch_angle  <= s.pitch_angle;
      req_if.elapsed_ms   <= s.elapsed_ms;
      do @(posedge clock); while (!req_if.ready);
      verdict = predict_verdict(s);
      if (typed) verdict = want;
      verdict_q = {verdict_q, verdict};
      n_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_GRAVITY_SQ_LOW:  cfg.gravity_sq_low         = data;
         CSR_GRAVITY_SQ_HIGH: cfg.gravity_sq_high        = data;
         CSR_FALLEN_ANGLE:    cfg.fallen_angle           = data[14:0];
         CSR_ROLL_LIMIT:      cfg.roll_falling_limit     = data[14:0];
         CSR_FORWARD_LIMIT:   cfg.forward_falling_limit  = data[14:0];
         CSR_BACKWARD_LIMIT:  cfg.backward_falling_limit = data[14:0];
         CSR_FALLEN_TIME:     cfg.fallen_time_limit      = data[15:0];
         default: ;
      endcase
   endtask

   task automatic program_regs();
      write_reg(CSR_GRAVITY_SQ_LOW,  reg_words[0]);
      write_reg(CSR_GRAVITY_SQ_HIGH, reg_words[1]);
      write_reg(CSR_FALLEN_ANGLE,    reg_words[2]);
      write_reg(CSR_ROLL_LIMIT,      reg_words[3]);
      write_reg(CSR_FORWARD_LIMIT,   reg_words[4]);
      write_reg(CSR_BACKWARD_LIMIT,  reg_words[5]);
      write_reg(CSR_FALLEN_TIME,     reg_words[6]);
      write_reg(CSR_INDEX_UNUSED,    $urandom);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side back pressure in bursts
   always @(negedge clock) begin
      if (calm) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 10);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Result check on every transfer
   always @(posedge clock) begin
      fall_result_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.result_valid, rsp_if.fallen, rsp_if.fallen_left,
                rsp_if.fallen_right, rsp_if.fallen_front, rsp_if.fallen_back,
                rsp_if.falling_left, rsp_if.falling_right, rsp_if.falling_forward,
                rsp_if.falling_backward, rsp_if.falling_count};
         if (verdict_q.size() == 0) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
               $display("unexpected result at cycle %0d: %s", cycle_count, show_result(got));
         end else begin
            want = verdict_q.pop_front();
            n_checked++;
            if (got !== want) begin
               n_bad++;
               if (n_bad <= MAX_REPORTS) begin
                  $display("mismatch on result %0d at cycle %0d", n_checked, cycle_count);
                  $display("   expected %s", show_result(want));
                  $display("   actual   %s", show_result(got));
               end
            end
            if (!got.result_valid)       n_invalid++;
            else if (got.fallen)         n_fallen++;
            else if (got.falling_count)  n_falling++;
         end
      end
   end

   initial begin
      int p, k;

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.sample_valid = 1'b0;
      req_if.accel_x      = '0;
      req_if.accel_y      = '0;
      req_if.accel_z      = '0;
      req_if.roll_angle   = '0;
      req_if.pitch_angle  = '0;
      req_if.elapsed_ms   = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = '0;
      csr_if.wdata        = '0;

      cfg.gravity_sq_low         = RST_GRAVITY_SQ_LOW;
      cfg.gravity_sq_high        = RST_GRAVITY_SQ_HIGH;
      cfg.fallen_angle           = RST_FALLEN_ANGLE;
      cfg.roll_falling_limit     = RST_ROLL_LIMIT;
      cfg.forward_falling_limit  = RST_FORWARD_LIMIT;
      cfg.backward_falling_limit = RST_BACKWARD_LIMIT;
      cfg.fallen_time_limit      = RST_FALLEN_TIME;
      lying_ms = '0;

      // Directed samples under the reset register values
      add_row(smp(0, -32768, -32768, -32768, -32768, -32768, 65535), 1'b1, RES_INVALID);
      add_row(smp(1, 0, 0, 981, 0, 0, 10), 1'b1, falling_only(0, 0, 0, 0));
      add_row(smp(1, -32768, -32768, -32768, -32768, 32767, 65535), 1'b1,
              falling_only(1, 0, 1, 0));
      add_row(smp(1, 32767, 32767, 32767, 32767, -32768, 0), 1'b1, falling_only(0, 1, 0, 1));
      add_row(smp(1, 0, 0, 0, 0, 0, 0), 1'b1, falling_only(0, 0, 0, 0));
      // falling limits: exactly at, and one past
      add_row(smp(1, 0, 0, 981, 2253, -1843, 5), 1'b1, falling_only(0, 0, 0, 0));
      add_row(smp(1, 0, 0, 981, -2254, -1844, 5), 1'b1, falling_only(1, 0, 0, 1));
      add_row(smp(1, 0, 0, 981, -2253, 2254, 5), 1'b1, falling_only(0, 0, 1, 0));
      // lying run reaching the time limit, then one past it
      add_row(smp(1, 0, 981, 0, 4507, 0, 60), 1'b0, RES_INVALID);
      add_row(smp(1, 0, 981, 0, 4507, 0, 40), 1'b0, RES_INVALID);
      add_row(smp(1, 0, 981, 0, 4507, 0, 1), 1'b0, RES_INVALID);
      // invalid sample keeps the timer
      add_row(smp(0, 0, 981, 0, 4507, 0, 500), 1'b1, RES_INVALID);
      add_row(smp(1, 0, -981, 0, 0, -4507, 0), 1'b0, RES_INVALID);
      add_row(smp(1, 981, 0, 0, 0, -4507, 0), 1'b0, RES_INVALID);
      add_row(smp(1, -981, 0, 0, 4600, 0, 0), 1'b0, RES_INVALID);
      // equal x and y magnitudes, then zero on both axes
      add_row(smp(1, 700, 700, 0, 4600, 0, 0), 1'b0, RES_INVALID);
      add_row(smp(1, 700, -700, 0, 4600, 0, 0), 1'b0, RES_INVALID);
      add_row(smp(1, 0, 0, 981, 0, -4600, 0), 1'b0, RES_INVALID);
      // timer saturation, most negative angle
      add_row(smp(1, 0, 0, 981, -32768, 0, 65535), 1'b0, RES_INVALID);
      add_row(smp(1, 0, 0, 981, 0, -32768, 65535), 1'b0, RES_INVALID);
      // angle exactly at fallen_angle clears the timer
      add_row(smp(1, 0, 0, 981, 4506, 4506, 10), 1'b0, RES_INVALID);
      // gravity window edges
      add_row(smp(1, 0, 0, 784, 4600, 0, 20), 1'b0, RES_INVALID);
      add_row(smp(1, 0, 0, 785, 4600, 0, 20), 1'b0, RES_INVALID);
      add_row(smp(1, 0, 0, 1177, 0, 4600, 20), 1'b0, RES_INVALID);
      add_row(smp(1, 0, 0, 1178, 0, 4600, 20), 1'b0, RES_INVALID);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);

      // Random phases, each under its own register setting
      for (p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p)
            0: begin
               reg_words[0] = RST_GRAVITY_SQ_LOW;
               reg_words[1] = RST_GRAVITY_SQ_HIGH;
               reg_words[2] = 32'(RST_FALLEN_ANGLE);
               reg_words[3] = 32'(RST_ROLL_LIMIT);
               reg_words[4] = 32'(RST_FORWARD_LIMIT);
               reg_words[5] = 32'(RST_BACKWARD_LIMIT);
               reg_words[6] = 32'(RST_FALLEN_TIME);
            end
            2: begin
               // window closed at the top, every limit zero
               reg_words[0] = GRAVITY_SQ_MAX;
               reg_words[1] = GRAVITY_SQ_MAX;
               for (k = 2; k < 7; k++) reg_words[k] = '0;
            end
            3: begin
               // zero low bound, all else ones: angles and time get masked to their widths
               reg_words[0] = '0;
               for (k = 1; k < 7; k++) reg_words[k] = '1;
            end
            4: begin
               reg_words[0] = '0;
               reg_words[1] = GRAVITY_SQ_MAX;
               reg_words[2] = '0;
               reg_words[3] = $urandom_range(0, 32767);
               reg_words[4] = $urandom_range(0, 32767);
               reg_words[5] = $urandom_range(0, 32767);
               reg_words[6] = '0;
            end
            default: begin
               reg_words[0] = $urandom_range(400000, 900000);
               reg_words[1] = $urandom_range(1100000, 2000000);
               reg_words[2] = $urandom_range(2000, 9000);
               reg_words[3] = $urandom_range(0, 6000);
               reg_words[4] = $urandom_range(0, 6000);
               reg_words[5] = $urandom_range(0, 6000);
               reg_words[6] = $urandom_range(0, 300);
            end
         endcase
         calm = (p == NUM_PHASES - 1);
         program_regs();
         n_settings++;
         for (k = 0; k < PHASE_ITEMS; k++) send_sample(random_sample(), 1'b0, RES_INVALID);
      end

      drain();
      n_bad += verdict_q.size();

      $display("summary: %0d samples sent, %0d results checked, %0d register settings",
               n_sent, n_checked, n_settings);
      $display("summary: %0d fallen, %0d with falling flags, %0d invalid, %0d failures",
               n_fallen, n_falling, n_invalid, n_bad);
      if (n_bad == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
